@@ rtl/core/stochastic_universal_sampler_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stochastic universal sampler
// Shared property shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef STOCHASTIC_UNIVERSAL_SAMPLER_TOP_MACROS_SVH
`define STOCHASTIC_UNIVERSAL_SAMPLER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define SUS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sus: same-cycle check failed");

// next-cycle implication, disabled in reset
`define SUS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sus: next-cycle check failed");

`endif

@@ rtl/core/sus_pkg.sv @@
// ----------------------------------------------------------------------------
// sus_pkg
// Types and fixed widths shared by the stochastic universal sampler.
// ----------------------------------------------------------------------------
package sus_pkg;

  localparam int POP_W    = 7;
  localparam int IDX_W    = 6;
  localparam int WEIGHT_W = 32;
  localparam int FRAC_W   = 16;
  localparam int BIT_W    = 4;
  localparam int TOTAL_W  = 38;
  localparam int PW_W     = POP_W + WEIGHT_W;
  // total * (k*65536 + r) and p*65536*cum both stay below 2^60
  localparam int ACC_W    = 61;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PMUL,
    ST_RADD,
    ST_CMP,
    ST_OUT,
    ST_ERR
  } state_t;

  typedef enum logic [1:0] {
    ADD_MUL_STEP,
    ADD_R_STEP,
    ADD_L_STEP
  } add_sel_t;

  typedef struct packed {
    logic     clr;
    logic     l_load;
    logic     r_load;
    logic     pw_load;
    logic     mul_bit;
    add_sel_t add_sel;
  } dp_ctrl_t;

endpackage

@@ rtl/core/sus_store.sv @@
// ----------------------------------------------------------------------------
// sus_store
// Weight memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sus_store #(
  parameter int DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH)-1:0]        waddr,
  input  logic [sus_pkg::WEIGHT_W-1:0]    wdata,
  input  logic                            re,
  input  logic [$clog2(DEPTH)-1:0]        raddr,
  output logic [sus_pkg::WEIGHT_W-1:0]    rdata_r
);

  logic [sus_pkg::WEIGHT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/sus_dp.sv @@
// ----------------------------------------------------------------------------
// sus_dp
// Shared 61-bit adder and comparator for the sampling point and cumulative
// weight accumulators.
// ----------------------------------------------------------------------------
module sus_dp (
  input  logic                            clk,
  input  sus_pkg::dp_ctrl_t               ctrl,
  input  logic [sus_pkg::TOTAL_W-1:0]     total,
  input  logic [sus_pkg::POP_W-1:0]       pop_eff,
  input  logic [sus_pkg::WEIGHT_W-1:0]    rdata,
  output logic                            l_gt_r
);

  logic [sus_pkg::ACC_W-1:0] acc_l_r, acc_l_nxt;
  logic [sus_pkg::ACC_W-1:0] acc_r_r, acc_r_nxt;
  logic [sus_pkg::PW_W-1:0]  pw_r, pw_nxt;
  logic [sus_pkg::ACC_W-1:0] opa, opb, sum;

  // operand select for the one adder
  always_comb begin
    unique case (ctrl.add_sel)
      sus_pkg::ADD_MUL_STEP: begin
        opa = acc_l_r << 1;
        opb = ctrl.mul_bit ? sus_pkg::ACC_W'(total) : '0;
      end
      sus_pkg::ADD_R_STEP: begin
        opa = acc_r_r;
        opb = sus_pkg::ACC_W'(pw_r) << sus_pkg::FRAC_W;
      end
      sus_pkg::ADD_L_STEP: begin
        opa = acc_l_r;
        opb = sus_pkg::ACC_W'(total) << sus_pkg::FRAC_W;
      end
      default: begin
        opa = acc_l_r;
        opb = '0;
      end
    endcase
  end

  assign sum    = opa + opb;
  assign l_gt_r = acc_l_r > acc_r_r;

  always_comb begin
    acc_l_nxt = acc_l_r;
    acc_r_nxt = acc_r_r;
    pw_nxt    = pw_r;
    if (ctrl.clr) begin
      acc_l_nxt = '0;
      acc_r_nxt = '0;
    end else begin
      if (ctrl.l_load) begin
        acc_l_nxt = sum;
      end
      if (ctrl.r_load) begin
        acc_r_nxt = sum;
      end
    end
    if (ctrl.pw_load) begin
      pw_nxt = sus_pkg::PW_W'(pop_eff) * sus_pkg::PW_W'(rdata);
    end
  end

  always_ff @(posedge clk) begin
    acc_l_r <= acc_l_nxt;
    acc_r_r <= acc_r_nxt;
    pw_r    <= pw_nxt;
  end

endmodule

@@ rtl/core/sus_ctrl.sv @@
// ----------------------------------------------------------------------------
// sus_ctrl
// Sequencer: weight loading, population register, sampling walk.
// ----------------------------------------------------------------------------
module sus_ctrl #(
  parameter int MAX_POPULATION = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sus_pkg::POP_W-1:0]            cfg_population_size,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_kind,
  input  logic [sus_pkg::WEIGHT_W-1:0]         in_weight,
  input  logic [sus_pkg::FRAC_W-1:0]           in_random_fraction,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sus_pkg::IDX_W-1:0]            out_parent_index,
  output logic                                 out_status,
  output logic                                 out_last,
  output logic                                 mem_we,
  output logic [$clog2(MAX_POPULATION)-1:0]    mem_waddr,
  output logic                                 mem_re,
  output logic [$clog2(MAX_POPULATION)-1:0]    mem_raddr,
  output sus_pkg::dp_ctrl_t                    dp_ctrl,
  output logic [sus_pkg::TOTAL_W-1:0]          total,
  output logic [sus_pkg::POP_W-1:0]            pop_eff,
  input  logic                                 l_gt_r
);

  localparam int AW = $clog2(MAX_POPULATION);
  localparam logic [sus_pkg::POP_W-1:0] POP_MIN = sus_pkg::POP_W'(2);
  localparam logic [sus_pkg::POP_W-1:0] POP_MAX = sus_pkg::POP_W'(MAX_POPULATION);

  sus_pkg::state_t state_r, state_nxt;

  logic [sus_pkg::POP_W-1:0]   pop_r, pop_nxt;
  logic [sus_pkg::POP_W-1:0]   cnt_r, cnt_nxt;
  logic [sus_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [sus_pkg::FRAC_W-1:0]  frac_r, frac_nxt;
  logic [sus_pkg::BIT_W-1:0]   bit_r, bit_nxt;
  logic [AW-1:0]               k_r, k_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;

  logic cfg_wr, in_acc, out_acc, is_start, loaded, advance, run_last;

  // register writes only land between runs; a pending write holds off input items
  assign cfg_ready = (state_r == sus_pkg::ST_IDLE);
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_stall  = (state_r != sus_pkg::ST_IDLE) | cfg_valid;
  assign in_acc    = in_valid & ~in_stall;
  assign out_acc   = out_valid & ~out_stall;
  assign is_start  = (in_kind == sus_pkg::KIND_START);

  always_comb begin
    priority if (pop_r < POP_MIN) begin
      pop_eff = POP_MIN;
    end else if (pop_r > POP_MAX) begin
      pop_eff = POP_MAX;
    end else begin
      pop_eff = pop_r;
    end
  end

  assign loaded   = (cnt_r >= pop_eff);
  assign advance  = (sus_pkg::POP_W'(idx_r) < pop_eff - sus_pkg::POP_W'(1)) & l_gt_r;
  assign run_last = (sus_pkg::POP_W'(k_r) == pop_eff - sus_pkg::POP_W'(1));
  assign total    = total_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sus_pkg::ST_IDLE: begin
        if (in_acc && !cfg_wr && is_start) begin
          state_nxt = loaded ? sus_pkg::ST_MUL : sus_pkg::ST_ERR;
        end
      end
      sus_pkg::ST_MUL: begin
        if (bit_r == '0) begin
          state_nxt = sus_pkg::ST_PMUL;
        end
      end
      sus_pkg::ST_PMUL: state_nxt = sus_pkg::ST_RADD;
      sus_pkg::ST_RADD: state_nxt = sus_pkg::ST_CMP;
      sus_pkg::ST_CMP: begin
        state_nxt = advance ? sus_pkg::ST_PMUL : sus_pkg::ST_OUT;
      end
      sus_pkg::ST_OUT: begin
        if (out_acc) begin
          state_nxt = run_last ? sus_pkg::ST_IDLE : sus_pkg::ST_CMP;
        end
      end
      sus_pkg::ST_ERR: begin
        if (out_acc) begin
          state_nxt = sus_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sus_pkg::ST_IDLE;
    endcase
  end

  // outputs and unit controls
  always_comb begin
    out_valid        = 1'b0;
    out_parent_index = sus_pkg::IDX_W'(idx_r);
    out_status       = sus_pkg::STATUS_OK;
    out_last         = run_last;
    mem_we           = 1'b0;
    mem_waddr        = cnt_r[AW-1:0];
    mem_re           = 1'b0;
    mem_raddr        = '0;
    dp_ctrl          = '0;
    dp_ctrl.mul_bit  = frac_r[bit_r];
    dp_ctrl.add_sel  = sus_pkg::ADD_MUL_STEP;
    unique case (state_r)
      sus_pkg::ST_IDLE: begin
        if (in_acc && !cfg_wr) begin
          if (is_start) begin
            // prefetch entry 0 while the offset product is built
            mem_re      = 1'b1;
            dp_ctrl.clr = 1'b1;
          end else begin
            mem_we = ~loaded;
          end
        end
      end
      sus_pkg::ST_MUL: begin
        dp_ctrl.add_sel = sus_pkg::ADD_MUL_STEP;
        dp_ctrl.l_load  = 1'b1;
      end
      sus_pkg::ST_PMUL: begin
        dp_ctrl.pw_load = 1'b1;
      end
      sus_pkg::ST_RADD: begin
        dp_ctrl.add_sel = sus_pkg::ADD_R_STEP;
        dp_ctrl.r_load  = 1'b1;
      end
      sus_pkg::ST_CMP: begin
        mem_re    = advance;
        mem_raddr = idx_r + AW'(1);
      end
      sus_pkg::ST_OUT: begin
        out_valid       = 1'b1;
        dp_ctrl.add_sel = sus_pkg::ADD_L_STEP;
        dp_ctrl.l_load  = out_acc & ~run_last;
      end
      sus_pkg::ST_ERR: begin
        out_valid        = 1'b1;
        out_parent_index = '0;
        out_status       = sus_pkg::STATUS_ERR;
        out_last         = 1'b1;
      end
      default: ;
    endcase
  end

  // register next values
  always_comb begin
    pop_nxt   = pop_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    frac_nxt  = frac_r;
    bit_nxt   = bit_r;
    k_nxt     = k_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      sus_pkg::ST_IDLE: begin
        priority if (cfg_wr) begin
          pop_nxt   = cfg_population_size;
          cnt_nxt   = '0;
          total_nxt = '0;
        end else if (in_acc) begin
          if (is_start) begin
            frac_nxt = in_random_fraction;
            bit_nxt  = '1;
            k_nxt    = '0;
            idx_nxt  = '0;
          end else if (!loaded) begin
            cnt_nxt   = cnt_r + sus_pkg::POP_W'(1);
            total_nxt = total_r + sus_pkg::TOTAL_W'(in_weight);
          end
        end
      end
      sus_pkg::ST_MUL: bit_nxt = bit_r - sus_pkg::BIT_W'(1);
      sus_pkg::ST_CMP: begin
        if (advance) begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      sus_pkg::ST_OUT: begin
        if (out_acc) begin
          if (run_last) begin
            cnt_nxt   = '0;
            total_nxt = '0;
          end else begin
            k_nxt = k_r + AW'(1);
          end
        end
      end
      sus_pkg::ST_ERR: begin
        if (out_acc) begin
          cnt_nxt   = '0;
          total_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sus_pkg::ST_IDLE;
      pop_r   <= POP_MAX;
      cnt_r   <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      pop_r   <= pop_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frac_r <= frac_nxt;
    bit_r  <= bit_nxt;
    k_r    <= k_nxt;
    idx_r  <= idx_nxt;
  end

endmodule

@@ rtl/core/stochastic_universal_sampler_top.sv @@
// Load item: taken without leaving idle; a new item can follow unless cfg_valid is high.
// Start item: total*r is built by shift-add on the shared adder, then each step of the
// walk reads a weight, forms the p*w product and accumulates it, and each result is a
// compare and then an emit, which out_stall can hold.
// A start with too few weights gives its single error result on the next cycle.
// Synchronous active-low reset clears control state; population size resets to 64.
// ----------------------------------------------------------------------------
// stochastic_universal_sampler_top
// Stochastic universal sampling for GA parent selection, exact integer compare.
// ----------------------------------------------------------------------------
module stochastic_universal_sampler_top #(
  parameter int MAX_POPULATION = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sus_pkg::POP_W-1:0]         cfg_population_size,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [sus_pkg::WEIGHT_W-1:0]      in_weight,
  input  logic [sus_pkg::FRAC_W-1:0]        in_random_fraction,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sus_pkg::IDX_W-1:0]         out_parent_index,
  output logic                              out_status,
  output logic                              out_last
);

  localparam int AW = $clog2(MAX_POPULATION);

  logic                          mem_we, mem_re, l_gt_r;
  logic [AW-1:0]                 mem_waddr, mem_raddr;
  logic [sus_pkg::WEIGHT_W-1:0]  rdata;
  logic [sus_pkg::TOTAL_W-1:0]   total;
  logic [sus_pkg::POP_W-1:0]     pop_eff;
  sus_pkg::dp_ctrl_t             dp_ctrl;

  sus_ctrl #(
    .MAX_POPULATION(MAX_POPULATION)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_population_size (cfg_population_size),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_weight           (in_weight),
    .in_random_fraction  (in_random_fraction),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_parent_index    (out_parent_index),
    .out_status          (out_status),
    .out_last            (out_last),
    .mem_we              (mem_we),
    .mem_waddr           (mem_waddr),
    .mem_re              (mem_re),
    .mem_raddr           (mem_raddr),
    .dp_ctrl             (dp_ctrl),
    .total               (total),
    .pop_eff             (pop_eff),
    .l_gt_r              (l_gt_r)
  );

  sus_store #(
    .DEPTH(MAX_POPULATION)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (in_weight),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (rdata)
  );

  sus_dp u_dp (
    .clk     (clk),
    .ctrl    (dp_ctrl),
    .total   (total),
    .pop_eff (pop_eff),
    .rdata   (rdata),
    .l_gt_r  (l_gt_r)
  );

endmodule

@@ rtl/core/sus_checker.sv @@
// ----------------------------------------------------------------------------
// sus_checker
// Port-level checks for the sampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "stochastic_universal_sampler_top_macros.svh"

module sus_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [sus_pkg::IDX_W-1:0]     out_parent_index,
  input logic                          out_status,
  input logic                          out_last
);

  logic err_out;

  assign err_out = out_valid && (out_status == sus_pkg::STATUS_ERR);

  // an error result is a run of one with index zero
  `SUS_ASSERT_IMPLY(a_err_last, clk, rst_n, err_out, out_last)
  `SUS_ASSERT_IMPLY(a_err_idx, clk, rst_n, err_out, out_parent_index == '0)
  // no new item while a result is pending
  `SUS_ASSERT_IMPLY(a_busy_out, clk, rst_n, out_valid, in_stall)
  // a non-final result is followed by more of the same run, never by input
  `SUS_ASSERT_NEXT(a_run_cont, clk, rst_n, out_valid && !out_stall && !out_last, in_stall)
  `SUS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_parent_index) && $stable(out_last))

endmodule

bind stochastic_universal_sampler_top sus_checker u_sus_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_parent_index (out_parent_index),
  .out_status       (out_status),
  .out_last         (out_last)
);

@@ tb/stochastic_universal_sampler_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stochastic_universal_sampler_top_tb
// Self-checking bench for the stochastic universal sampler. Weight loads and
// selection starts go in through a bursty driver. A scoreboard computes each
// run's parent indices with exact 64-bit arithmetic and checks every result
// item. Population size changes only between idle phases.
// ----------------------------------------------------------------------------
module stochastic_universal_sampler_top_tb;

  localparam int MAX_POP      = 64;
  localparam int SETTLE       = 10;     // cycles for a trailing load item to finish
  localparam int RANDOM_ITEMS = 300;

  typedef struct {
    logic                         kind;
    logic [sus_pkg::WEIGHT_W-1:0] weight;
    logic [sus_pkg::FRAC_W-1:0]   frac;
  } item_t;

  typedef struct {
    logic [sus_pkg::IDX_W-1:0] idx;
    logic                      status;
    logic                      last;
  } pick_t;

  typedef enum {W_FULL, W_SMALL, W_ZERO, W_MAX, W_MIXED} wt_style_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [sus_pkg::POP_W-1:0]    cfg_population_size = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_kind = sus_pkg::KIND_LOAD;
  logic [sus_pkg::WEIGHT_W-1:0] in_weight = '0;
  logic [sus_pkg::FRAC_W-1:0]   in_random_fraction = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [sus_pkg::IDX_W-1:0]    out_parent_index;
  logic                         out_status;
  logic                         out_last;

  stochastic_universal_sampler_top #(.MAX_POPULATION(MAX_POP)) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_population_size (cfg_population_size),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_weight           (in_weight),
    .in_random_fraction  (in_random_fraction),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_parent_index    (out_parent_index),
    .out_status          (out_status),
    .out_last            (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scoreboard state
  logic [sus_pkg::WEIGHT_W-1:0] w_store [MAX_POP];
  int unsigned                  n_loaded = 0;
  logic [sus_pkg::TOTAL_W-1:0]  w_sum = '0;
  logic [sus_pkg::POP_W-1:0]    pop_reg = 7'd64;
  pick_t                        parents_due [$];
  item_t                        pending_items [$];
  int                           errors = 0;
  logic                         item_taken = 1'b0;

  function automatic int unsigned eff_pop();
    int unsigned p;
    p = pop_reg;
    if (p < 2) p = 2;
    if (p > MAX_POP) p = MAX_POP;
    return p;
  endfunction

  // Apply one accepted item to the scoreboard; a start queues its parent picks.
  function automatic void predict_parents(logic kind, logic [sus_pkg::WEIGHT_W-1:0] w,
                                          logic [sus_pkg::FRAC_W-1:0] r);
    int unsigned       p;
    int unsigned       idx;
    longint unsigned   total;
    longint unsigned   cum;
    longint unsigned   lhs;
    pick_t             res;
    p = eff_pop();
    if (kind == sus_pkg::KIND_LOAD) begin
      if (n_loaded < p) begin
        w_store[n_loaded] = w;
        w_sum = w_sum + w;
        n_loaded++;
      end
      return;
    end
    if (n_loaded < p) begin
      res.idx = '0;
      res.status = sus_pkg::STATUS_ERR;
      res.last = 1'b1;
      parents_due.push_back(res);
    end else begin
      total = 64'(w_sum);
      cum = 64'(w_store[0]);
      idx = 0;
      for (int unsigned k = 0; k < p; k++) begin
        // sample point exceeds cum when total*(k*65536 + r) > p*65536*cum
        lhs = total * ((64'(k) << 16) + 64'(r));
        while (idx < p - 1 && lhs > ((64'(p) << 16) * cum)) begin
          idx++;
          cum += 64'(w_store[idx]);
        end
        res.idx = sus_pkg::IDX_W'(idx);
        res.status = sus_pkg::STATUS_OK;
        res.last = (k == p - 1);
        parents_due.push_back(res);
      end
    end
    n_loaded = 0;
    w_sum = '0;
  endfunction

  // input driver: bursts of items with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin : drive_in
    item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        in_kind <= nxt.kind;
        in_weight <= nxt.weight;
        in_random_fraction <= nxt.frac;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall pattern: none, scattered, or runs, switching every so often
  int  stall_mode = 0;
  int  mode_left = 0;
  int  run_left = 0;
  bit  run_on = 1'b0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(64, 256);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (run_left == 0) begin
          run_on = !run_on;
          run_left = $urandom_range(1, 8);
        end else begin
          run_left--;
        end
        out_stall <= run_on;
      end
    endcase
  end

  always @(posedge clk) begin : watch
    pick_t want;
    item_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      predict_parents(in_kind, in_weight, in_random_fraction);
    if (rst_n && out_valid && !out_stall) begin
      if (parents_due.size() == 0) begin
        $error("unexpected result item: parent_index %0d status %0d last %0d",
               out_parent_index, out_status, out_last);
        errors++;
      end else begin
        want = parents_due.pop_front();
        if (out_parent_index !== want.idx) begin
          $error("parent_index mismatch: expected %0d, got %0d", want.idx, out_parent_index);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last mismatch: expected %0d, got %0d", want.last, out_last);
          errors++;
        end
      end
    end
  end

  task automatic push_item(input logic kind, input logic [sus_pkg::WEIGHT_W-1:0] w,
                           input logic [sus_pkg::FRAC_W-1:0] r);
    item_t it;
    it.kind = kind;
    it.weight = w;
    it.frac = r;
    pending_items.push_back(it);
  endtask

  task automatic push_load(input logic [sus_pkg::WEIGHT_W-1:0] w);
    push_item(sus_pkg::KIND_LOAD, w, sus_pkg::FRAC_W'($urandom));
  endtask

  task automatic push_start(input logic [sus_pkg::FRAC_W-1:0] r);
    push_item(sus_pkg::KIND_START, $urandom, r);
  endtask

  function automatic logic [sus_pkg::WEIGHT_W-1:0] pick_weight(wt_style_t s);
    case (s)
      W_SMALL: return $urandom_range(0, 15);
      W_ZERO:  return '0;
      W_MAX:   return '1;
      W_MIXED: return ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [sus_pkg::FRAC_W-1:0] pick_frac();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return sus_pkg::FRAC_W'($urandom);
    endcase
  endfunction

  function automatic logic [sus_pkg::POP_W-1:0] pick_pop();
    case ($urandom_range(0, 15))
      0: return sus_pkg::POP_W'($urandom_range(0, 127));
      1: return 7'd64;
      2: return sus_pkg::POP_W'($urandom_range(65, 127));
      3: return sus_pkg::POP_W'($urandom_range(0, 1));
      4, 5: return sus_pkg::POP_W'($urandom_range(9, 20));
      default: return sus_pkg::POP_W'($urandom_range(2, 8));
    endcase
  endfunction

  task automatic load_weights(input int unsigned n, input wt_style_t s);
    repeat (n) push_load(pick_weight(s));
  endtask

  // wait until every item is taken and every result has come back
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || parents_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_pop(input logic [sus_pkg::POP_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_population_size = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pop_reg = v;
    n_loaded = 0;
    w_sum = '0;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int unsigned fed;
    int unsigned seqs_left;
    int unsigned p;
    int unsigned n;
    int unsigned sel;
    wt_style_t   style;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // population 64 out of reset, nothing loaded
    push_start(16'h0000);
    drain();
    set_pop(7'd0);                        // acts as 2
    push_load(32'hFFFF_FFFF);
    push_load(32'hFFFF_FFFF);
    push_start(16'hFFFF);
    push_load(32'h0);                     // all-zero total
    push_load(32'h0);
    push_start(16'h0000);
    push_load(32'h5555_5555);             // one short
    push_start(16'h5555);
    push_load(32'd5);
    push_load(32'hAAAA_AAAA);
    push_load(32'd9);                     // extra weight, ignored
    push_start(16'hAAAA);
    push_start(16'h8000);                 // back-to-back start, empty load
    drain();
    set_pop(7'd3);
    push_load(32'd1);
    push_load(32'd2);
    drain();
    set_pop(7'd1);                        // write drops the partial load
    push_load(32'h0);
    push_load(32'h8000_0000);
    push_start(16'h0001);
    drain();
    set_pop(7'd127);                      // acts as 64
    push_load(32'd3);
    push_load(32'd4);
    push_start(16'h7FFF);
    drain();

    fed = 0;
    seqs_left = 0;
    while (fed < RANDOM_ITEMS) begin
      if (seqs_left == 0) begin
        drain();
        set_pop(pick_pop());
        seqs_left = $urandom_range(1, 4);
      end
      seqs_left--;
      p = eff_pop();
      sel = $urandom_range(0, 9);
      style = wt_style_t'($urandom_range(0, 4));
      if (sel <= 6) begin
        load_weights(p, style);
        if (sel == 6) repeat ($urandom_range(1, 3)) push_load($urandom);
        push_start(pick_frac());
        fed += p + 1;
      end else if (sel <= 8) begin
        n = $urandom_range(0, p - 1);
        load_weights(n, style);
        push_start(pick_frac());
        fed += n + 1;
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) push_item($urandom_range(0, 1) ? sus_pkg::KIND_START : sus_pkg::KIND_LOAD,
                             $urandom, sus_pkg::FRAC_W'($urandom));
        fed += n;
      end
    end
    drain();

    if (parents_due.size() != 0) begin
      $error("%0d result items never arrived", parents_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
